// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the handshake responder RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off while reset is high.
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property on every rising clock edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: hw/rtl/hsr_pkg.sv
// Package for the handshake responder: message geometry, CRC constants,
// link phase and event codes. No dependencies.
`default_nettype none

package hsr_pkg;

   localparam int DATA_BYTES = 256;
   localparam int COUNT_W = 9;
   localparam logic [COUNT_W-1:0] MSG_BYTES = COUNT_W'(12 + DATA_BYTES);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] FLAG_SYN = 32'd0;
   localparam logic [31:0] FLAG_DATAACK = 32'd3;
   localparam logic [7:0] TIMEOUT_RESET = 8'd3;

   typedef enum logic [1:0] {
      PH_WAIT_SYN = 2'd0,
      PH_WAIT_ACK = 2'd1,
      PH_CONNECTED = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      EV_SYNACK = 3'd0,
      EV_RESEND = 3'd1,
      EV_CONNECTED = 3'd2,
      EV_BAD_SYN = 3'd3,
      EV_BAD_ACK = 3'd4,
      EV_IGNORED = 3'd5
   } event_type;

endpackage

`default_nettype wire

// File: hw/rtl/hsr_crc_byte.sv
// One-byte update of the reflected CRC-32, eight bit steps unrolled.
// Depends on hsr_pkg for the polynomial.
`default_nettype none

module hsr_crc_byte (
   input  logic [31:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [31:0] crc_next
);
   import hsr_pkg::*;

   always_comb begin
      logic [31:0] c;
      c = crc_cur ^ {24'b0, data_byte};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      crc_next = c;
   end

endmodule

`default_nettype wire

// File: hw/rtl/handshake_responder_crc32.sv
// Handshake responder: input register, single-pass message and timer logic,
// result register. Depends on hsr_pkg, hsr_crc_byte and assert_macros.svh.
// A request is held in the input register; its result, if any, is then loaded into the
// result register. Throughput: one request per cycle, limited only by rsp_tready.
// The CRC and state update are combinational through the unrolled byte CRC.
// Reset (synchronous, active high) empties both registers, clears the
// message state and the timer, sets the phase to wait-SYN and timeout to 3.
`default_nettype none

module handshake_responder_crc32 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_value
   input  logic       req_tuser,   // [0] operation
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [2:0] event_res, [4:3] link_state, [7:5] zero
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import hsr_pkg::*;
   `include "assert_macros.svh"

   logic                 in_valid_ff, in_valid_in;
   logic                 in_op_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_last_ff;
   logic [7:0]           timeout_ff;
   phase_type            phase_ff, phase_in;
   logic [31:0]          crc_ff, crc_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [31:0]          flag_ff, flag_in;
   logic [31:0]          check_ff, check_in;
   logic [7:0]           timer_left_ff, timer_left_in;
   logic                 timer_on_ff, timer_on_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   event_type            rsp_event_ff, rsp_event_in;
   phase_type            rsp_phase_ff;

   logic                 proceed, is_byte, is_tick;
   logic                 flag_zone, check_zone;
   logic [4:0]           shift_amt;
   logic [31:0]          flag_acc, check_acc, crc_next;
   logic [7:0]           crc_data;
   logic [COUNT_W-1:0]   count_inc;
   logic                 msg_ok, msg_end, syn_hit, ack_hit;
   logic [7:0]           timer_dec, arm_value;
   logic                 expire, resend, rsp_load;

   assign proceed = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proceed;
   assign is_byte = proceed && !in_op_ff;
   assign is_tick = proceed && in_op_ff;

   assign flag_zone = count_ff < COUNT_W'(4);
   assign check_zone = (count_ff >= COUNT_W'(8)) && (count_ff < COUNT_W'(12));
   assign shift_amt = {count_ff[1:0], 3'b000};
   assign flag_acc = flag_zone ? (flag_ff | ({24'b0, in_byte_ff} << shift_amt)) : flag_ff;
   assign check_acc = check_zone ? (check_ff | ({24'b0, in_byte_ff} << shift_amt))
                                 : check_ff;
   assign crc_data = check_zone ? 8'd0 : in_byte_ff;
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);

   hsr_crc_byte u_crc (
      .crc_cur   (crc_ff),
      .data_byte (crc_data),
      .crc_next  (crc_next)
   );

   assign msg_ok = (count_inc == MSG_BYTES) && (check_acc == crc_next);
   assign msg_end = is_byte && in_last_ff;
   assign syn_hit = msg_end && (phase_ff == PH_WAIT_SYN) && (flag_acc == FLAG_SYN);
   assign ack_hit = msg_end && (phase_ff == PH_WAIT_ACK) && (flag_acc == FLAG_DATAACK);

   assign timer_dec = timer_left_ff - {7'd0, timer_left_ff != 8'd0};
   assign expire = is_tick && timer_on_ff && (timer_dec == 8'd0);
   assign resend = expire && (phase_ff == PH_WAIT_ACK);
   assign arm_value = (timeout_ff == 8'd0) ? 8'd1 : timeout_ff;

   // next state
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (proceed) begin
         in_valid_in = 1'b0;
      end

      crc_in = crc_ff;
      count_in = count_ff;
      flag_in = flag_ff;
      check_in = check_ff;
      if (msg_end) begin
         crc_in = '0;
         count_in = '0;
         flag_in = '0;
         check_in = '0;
      end else if (is_byte) begin
         crc_in = crc_next;
         count_in = count_inc;
         flag_in = flag_acc;
         check_in = check_acc;
      end

      phase_in = phase_ff;
      case (phase_ff)
         PH_WAIT_SYN: begin
            if (syn_hit && msg_ok) phase_in = PH_WAIT_ACK;
         end
         PH_WAIT_ACK: begin
            if (ack_hit && msg_ok) phase_in = PH_CONNECTED;
         end
         PH_CONNECTED: begin
            phase_in = PH_CONNECTED;
         end
         default: begin
            phase_in = PH_WAIT_SYN;
         end
      endcase

      timer_left_in = timer_left_ff;
      timer_on_in = timer_on_ff;
      if (syn_hit && msg_ok) begin
         timer_left_in = arm_value;
         timer_on_in = 1'b1;
      end else if (ack_hit) begin
         timer_left_in = 8'd0;
         timer_on_in = 1'b0;
      end else if (is_tick && timer_on_ff) begin
         timer_left_in = timer_dec;
         if (resend) begin
            timer_left_in = arm_value;
         end else if (expire) begin
            timer_on_in = 1'b0;
         end
      end
   end

   // outputs
   always_comb begin
      rsp_load = msg_end || resend;
      rsp_event_in = EV_IGNORED;
      if (resend) begin
         rsp_event_in = EV_RESEND;
      end else if (syn_hit) begin
         rsp_event_in = msg_ok ? EV_SYNACK : EV_BAD_SYN;
      end else if (ack_hit) begin
         rsp_event_in = msg_ok ? EV_CONNECTED : EV_BAD_ACK;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         timeout_ff <= TIMEOUT_RESET;
         phase_ff <= PH_WAIT_SYN;
         crc_ff <= '0;
         count_ff <= '0;
         flag_ff <= '0;
         check_ff <= '0;
         timer_left_ff <= '0;
         timer_on_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) timeout_ff <= csr_wr_data;
         phase_ff <= phase_in;
         crc_ff <= crc_in;
         count_ff <= count_in;
         flag_ff <= flag_in;
         check_ff <= check_in;
         timer_left_ff <= timer_left_in;
         timer_on_ff <= timer_on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff <= req_tuser;
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (rsp_load) begin
         rsp_event_ff <= rsp_event_in;
         rsp_phase_ff <= phase_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b000, 2'(rsp_phase_ff), 3'(rsp_event_ff)};

   `ASSERT_RST(a_timer_nonzero, clock, reset,
      timer_on_ff |-> (timer_left_ff != 8'd0))
   `ASSERT_RST(a_connected_idle_timer, clock, reset,
      (phase_ff == PH_CONNECTED) |-> !timer_on_ff)
   `ASSERT_RST(a_connected_event, clock, reset,
      (rsp_valid_ff && (rsp_event_ff == EV_CONNECTED)) |-> (rsp_phase_ff == PH_CONNECTED))
   `ASSERT_RST(a_synack_on_open, clock, reset,
      (phase_ff == PH_WAIT_SYN) ##1 (phase_ff == PH_WAIT_ACK)
         |-> (rsp_valid_ff && (rsp_event_ff == EV_SYNACK)))

endmodule

`default_nettype wire

// File: tb/sv/hsr_link_monitor.sv
// Link monitor for the handshake responder: watches the request, response and
// register ports, predicts each response and compares it field by field.
// Depends on hsr_pkg for the phase and event codes and the CRC constants.
module hsr_link_monitor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output int         fail_count,
   output int         pending,
   output int         checked
);
   import hsr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      event_type  ev;
      phase_type  ph;
   } reply_type;

   reply_type replies_due[$];

   logic [7:0]         timeout_cfg;
   phase_type          link_phase;
   logic [31:0]        crc_acc;
   logic [31:0]        flag_acc;
   logic [31:0]        check_acc;
   logic [COUNT_W-1:0] byte_count;
   logic [7:0]         timer_left;
   logic               timer_on;

   function automatic logic [31:0] crc32_shift_byte(input logic [31:0] crc,
                                                    input logic [7:0] b);
      logic [31:0] r;
      int k;
      r = crc ^ {24'd0, b};
      for (k = 0; k < 8; k++)
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic void arm_ack_timer();
      timer_left = (timeout_cfg == 8'd0) ? 8'd1 : timeout_cfg;
      timer_on = 1'b1;
   endfunction

   function automatic void queue_reply(input event_type ev);
      reply_type r;
      r.ev = ev;
      r.ph = link_phase;
      replies_due.push_back(r);
   endfunction

   function automatic void advance_link(input logic op, input logic [7:0] b,
                                        input logic lst);
      logic        ok;
      logic [31:0] flag;
      event_type   ev;
      if (op) begin
         if (!timer_on)
            return;
         if (timer_left != 8'd0)
            timer_left--;
         if (timer_left != 8'd0)
            return;
         if (link_phase == PH_WAIT_ACK) begin
            arm_ack_timer();
            queue_reply(EV_RESEND);
         end else begin
            timer_on = 1'b0;
         end
         return;
      end
      if (byte_count < 4)
         flag_acc |= {24'd0, b} << (8 * byte_count);
      if (byte_count >= 8 && byte_count < 12) begin
         check_acc |= {24'd0, b} << (8 * (byte_count - 8));
         crc_acc = crc32_shift_byte(crc_acc, 8'd0);
      end else begin
         crc_acc = crc32_shift_byte(crc_acc, b);
      end
      if (byte_count != COUNT_MAX)
         byte_count++;
      if (!lst)
         return;
      ok = (byte_count == MSG_BYTES) && (check_acc == crc_acc);
      flag = flag_acc;
      crc_acc = '0;
      byte_count = '0;
      flag_acc = '0;
      check_acc = '0;
      ev = EV_IGNORED;
      if (link_phase == PH_WAIT_SYN && flag == FLAG_SYN) begin
         if (ok) begin
            arm_ack_timer();
            link_phase = PH_WAIT_ACK;
            ev = EV_SYNACK;
         end else begin
            ev = EV_BAD_SYN;
         end
      end else if (link_phase == PH_WAIT_ACK && flag == FLAG_DATAACK) begin
         timer_on = 1'b0;
         timer_left = '0;
         if (ok) begin
            link_phase = PH_CONNECTED;
            ev = EV_CONNECTED;
         end else begin
            ev = EV_BAD_ACK;
         end
      end
      queue_reply(ev);
   endfunction

   always @(posedge clock) begin : watch
      reply_type due;
      if (reset) begin
         timeout_cfg = TIMEOUT_RESET;
         link_phase = PH_WAIT_SYN;
         crc_acc = '0;
         flag_acc = '0;
         check_acc = '0;
         byte_count = '0;
         timer_left = '0;
         timer_on = 1'b0;
         replies_due.delete();
         pending <= 0;
      end else begin
         if (csr_wr_en)
            timeout_cfg = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               fail_count <= fail_count + 1;
               $display("%0t: unexpected response: expected none, got event %0d phase %0d",
                        $time, rsp_tdata[2:0], rsp_tdata[4:3]);
            end else begin
               due = replies_due.pop_front();
               checked <= checked + 1;
               if (rsp_tdata[2:0] !== due.ev || rsp_tdata[4:3] !== due.ph ||
                   rsp_tdata[7:5] !== 3'd0) begin
                  fail_count <= fail_count + 1;
                  $display("%0t: response mismatch: expected event %0d phase %0d pad 0,",
                           $time, due.ev, due.ph);
                  $display("   got event %0d phase %0d pad %0d",
                           rsp_tdata[2:0], rsp_tdata[4:3], rsp_tdata[7:5]);
               end
            end
         end
         if (req_tvalid && req_tready)
            advance_link(req_tuser, req_tdata, req_tlast);
         pending <= replies_due.size();
      end
   end

endmodule

// File: tb/sv/tb.sv
// Testbench top for handshake_responder_crc32: clock, reset, request and
// register stimulus, response back-pressure and the final verdict.
// Depends on hsr_pkg, the block itself and hsr_link_monitor.
module tb;
   import hsr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200_000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 6;
   localparam int MAX_MSG = 600;
   localparam int OVERLONG_BYTES = 515;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;
   logic       req_tuser = 1'b0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;

   int fail_count;
   int pending;
   int checked;
   int cycle_count = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int n_requests = 0;
   int n_ticks = 0;
   int hold_n;
   bit hold_pending = 1'b0;

   handshake_responder_crc32 u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   hsr_link_monitor u_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("handshake_responder_crc32 regression: fail");
         $finish;
      end
   end

   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            for (hold_n = 0; hold_n < HOLD_CYCLES; hold_n++)
               @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   task automatic send_req(input logic op, input logic [7:0] b, input logic lst);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= b;
      req_tlast <= lst;
      do
         @(posedge clock);
      while (!req_tready);
      n_requests++;
      if (op)
         n_ticks++;
   endtask

   task automatic send_ticks(input int n);
      int i;
      for (i = 0; i < n; i++)
         send_req(1'b1, 8'($urandom), 1'($urandom));
   endtask

   task automatic send_msg(input logic [31:0] flag, input int len, input bit good,
                           input int tick_pct);
      logic [7:0] msg [0:MAX_MSG-1];
      logic [31:0] crc;
      int i;
      int k;
      crc = '0;
      for (i = 0; i < len; i++) begin
         if (i < 4)
            msg[i] = flag[8*i +: 8];
         else if (i >= 8 && i < 12)
            msg[i] = 8'd0;
         else
            msg[i] = 8'($urandom);
         crc ^= {24'd0, msg[i]};
         for (k = 0; k < 8; k++)
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
      if (!good)
         crc ^= 32'd1 << $urandom_range(0, 31);
      for (i = 8; i < 12 && i < len; i++)
         msg[i] = crc[8*(i-8) +: 8];
      for (i = 0; i < len; i++) begin
         if (i != 0 && $urandom_range(0, 99) < tick_pct)
            send_ticks(1);
         send_req(1'b0, msg[i], i == len - 1);
      end
   endtask

   task automatic send_noise(input bit allow_ack, input int tick_pct);
      logic [31:0] flag;
      case ($urandom_range(0, 2))
         0: flag = FLAG_SYN;
         1: flag = allow_ack ? FLAG_DATAACK : 32'($urandom);
         default: flag = 32'($urandom);
      endcase
      if (!allow_ack && flag == FLAG_DATAACK)
         flag = 32'hFFFF_FFFF;
      send_msg(flag, $urandom_range(1, 16), 1'($urandom), tick_pct);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [7:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      int i;
      int mid_timeout;
      int late_timeout;
      mid_timeout = $urandom_range(2, 9);
      late_timeout = $urandom_range(1, 255);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      tx_idle_pct = 30;
      rx_idle_pct = 67;
      write_timeout(8'd0);

      send_req(1'b1, 8'hFF, 1'b1);
      send_msg(FLAG_SYN, 1, 1'b1, 0);
      send_msg(32'h0000_00FF, 1, 1'b1, 0);
      send_msg(FLAG_DATAACK, 4, 1'b1, 0);
      send_msg(FLAG_SYN, 12, 1'b1, 20);
      send_ticks(2);

      for (i = 0; i < 6; i++) begin
         if ($urandom_range(0, 1))
            send_noise(1'b1, 10);
         else
            send_ticks($urandom_range(1, 6));
      end
      send_msg(FLAG_SYN, MSG_BYTES, 1'b1, 5);

      tx_idle_pct = 67;
      rx_idle_pct = 30;
      wait_drained();
      write_timeout(8'd1);
      hold_pending = 1'b1;
      send_ticks(40);
      for (i = 0; i < 5; i++) begin
         send_noise(1'b0, 30);
         send_ticks($urandom_range(1, 4));
      end
      wait_drained();
      write_timeout(8'(mid_timeout));
      for (i = 0; i < 5; i++) begin
         send_noise(1'b0, 20);
         send_ticks($urandom_range(1, 12));
      end
      wait_drained();
      write_timeout(8'd255);
      send_ticks(270);
      send_msg(FLAG_DATAACK, MSG_BYTES, 1'b0, 5);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      wait_drained();
      write_timeout(8'(late_timeout));
      for (i = 0; i < 4; i++) begin
         send_noise(1'b0, 10);
         send_ticks($urandom_range(1, 5));
      end
      send_msg(FLAG_DATAACK, OVERLONG_BYTES, 1'b1, 0);
      send_msg(FLAG_DATAACK, MSG_BYTES, 1'b1, 0);
      for (i = 0; i < 3; i++) begin
         send_noise(1'b1, 10);
         send_ticks($urandom_range(1, 3));
      end

      wait_drained();
      $display("covered %0d requests (%0d timer ticks) and %0d checked responses",
               n_requests, n_ticks, checked);
      $display("timeouts 0, 1, %0d, 255, %0d; bad SYN, resend, bad ACK, connect, overlong",
               mid_timeout, late_timeout);
      if (fail_count == 0 && pending == 0)
         $display("handshake_responder_crc32 regression: pass");
      else
         $display("handshake_responder_crc32 regression: fail");
      $finish;
   end

endmodule
